// ----- design/linear_probe_hash_set_core_defines.svh -----
// ----------------------------------------------------------------------------
// Linear probe hash set assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_SET_CORE_DEFINES_SVH
`define LINEAR_PROBE_HASH_SET_CORE_DEFINES_SVH

// check that expr holds at every edge
`define LPHS_ASSERT_ALWAYS(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// check that cons holds in the cycle where ante holds
`define LPHS_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// check that cons holds in the cycle after the one where ante holds
`define LPHS_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/lphs_pkg.sv -----
// ----------------------------------------------------------------------------
// Linear probe hash set package
// Defaults, field widths, operation, mark and status codes, memory control.
// ----------------------------------------------------------------------------
`default_nettype none

package lphs_pkg;

   localparam int CAPACITY_DEF  = 256;
   localparam int KEY_BITS_DEF  = 64;
   localparam int HASH_BITS_DEF = 32;

   localparam int TYPE_W   = 2;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 8;
   localparam int COUNT_W  = 9;
   localparam int MARK_W   = 2;

   localparam logic [COUNT_W-1:0] MAX_FILL_RESET = 9'd192;

   typedef logic [MARK_W-1:0] lphs_mark_type;

   localparam lphs_mark_type MARK_NEVER    = 2'd0;
   localparam lphs_mark_type MARK_OCCUPIED = 2'd1;
   localparam lphs_mark_type MARK_TOMB     = 2'd2;

   localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_LOOKUP = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_PRESENT   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_REMOVED   = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd5;

   typedef struct packed {
      logic rd_en;
      logic mark_we;
      logic key_we;
   } lphs_mem_ctl_type;

endpackage

`default_nettype wire

// ----- design/lphs_mod.sv -----
// ----------------------------------------------------------------------------
// Linear probe hash set start cell unit
// Reduces the request hash modulo the table capacity: a mask for a power of
// two, otherwise eight remainder steps per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module lphs_mod import lphs_pkg::*; #(
   parameter int CAPACITY  = CAPACITY_DEF,
   parameter int HASH_BITS = HASH_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [HASH_BITS-1:0]         hash,
   output logic                              done,
   output logic [$clog2(CAPACITY)-1:0]       pos
);

   localparam int IDXW    = $clog2(CAPACITY);
   localparam bit IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;

   generate
      if (IS_POW2) begin : g_mask
         logic            done_ff;
         logic [IDXW-1:0] pos_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               pos_ff <= IDXW'(hash);
            end
         end

         assign done = done_ff;
         assign pos  = pos_ff;
      end else begin : g_divide
         localparam int STEP_BITS = 8;
         localparam int NSTEP     = (HASH_BITS + STEP_BITS - 1) / STEP_BITS;
         localparam int PADW      = NSTEP * STEP_BITS;
         localparam int CNTW      = $clog2(NSTEP + 1);
         localparam int RW        = IDXW + 1;

         logic            busy_ff;
         logic            done_ff;
         logic [CNTW-1:0] cnt_ff;
         logic [PADW-1:0] sh_ff;
         logic [IDXW-1:0] rem_ff;
         logic [IDXW-1:0] rem_in;
         logic [RW-1:0]   r;

         always_comb begin
            r = {1'b0, rem_ff};
            for (int i = 0; i < STEP_BITS; i++) begin
               r = {r[IDXW-1:0], sh_ff[PADW-1-i]};
               if (r >= RW'(CAPACITY)) begin
                  r = r - RW'(CAPACITY);
               end
            end
            rem_in = r[IDXW-1:0];
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b0;
               cnt_ff  <= '0;
            end else begin
               done_ff <= 1'b0;
               if (start) begin
                  busy_ff <= 1'b1;
                  cnt_ff  <= CNTW'(NSTEP);
               end else if (busy_ff) begin
                  cnt_ff <= cnt_ff - 1'b1;
                  if (cnt_ff == CNTW'(1)) begin
                     busy_ff <= 1'b0;
                     done_ff <= 1'b1;
                  end
               end
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               sh_ff  <= PADW'(hash);
               rem_ff <= '0;
            end else if (busy_ff) begin
               sh_ff  <= sh_ff << STEP_BITS;
               rem_ff <= rem_in;
            end
         end

         assign done = done_ff;
         assign pos  = rem_ff;
      end
   endgenerate

endmodule

`default_nettype wire

// ----- design/lphs_table.sv -----
// ----------------------------------------------------------------------------
// Linear probe hash set table
// Key store and cell marks: one write port and one registered read port each.
// ----------------------------------------------------------------------------
`default_nettype none

module lphs_table import lphs_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int KEY_BITS = KEY_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire lphs_mem_ctl_type              ctl,
   input  wire logic [$clog2(CAPACITY)-1:0]   rd_addr,
   input  wire logic [$clog2(CAPACITY)-1:0]   wr_addr,
   input  wire logic [KEY_BITS-1:0]           wr_key,
   input  wire lphs_mark_type                 wr_mark,
   output logic [KEY_BITS-1:0]                rd_key,
   output lphs_mark_type                      rd_mark
);

   logic [KEY_BITS-1:0] key_mem  [CAPACITY];
   lphs_mark_type       mark_mem [CAPACITY];
   logic [KEY_BITS-1:0] rd_key_ff;
   lphs_mark_type       rd_mark_ff;

   always_ff @(posedge clock) begin
      if (ctl.key_we) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (ctl.rd_en) begin
         rd_key_ff <= key_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mark_we) begin
         mark_mem[wr_addr] <= wr_mark;
      end
      if (ctl.rd_en) begin
         rd_mark_ff <= mark_mem[rd_addr];
      end
   end

   assign rd_key  = rd_key_ff;
   assign rd_mark = rd_mark_ff;

endmodule

`default_nettype wire

// ----- design/linear_probe_hash_set_core.sv -----
// Flow: a request waits in S_HASH for the start cell (a registered mask for a
// power-of-two capacity, otherwise the remainder steps); S_PROBE then reads one
// cell per cycle through the table read port, and S_FINISH loads the response.
// One transaction at a time: requests stall until the response is loaded.
// Reset: a clearing pass marks every cell never used; requests stall during it,
// and csr writes are taken.
// ----------------------------------------------------------------------------
// Linear probe hash set core
// Open addressing set with linear probing and tombstones, fill limit in csr.
// ----------------------------------------------------------------------------
`default_nettype none

`include "linear_probe_hash_set_core_defines.svh"

module linear_probe_hash_set_core import lphs_pkg::*; #(
   parameter int CAPACITY  = CAPACITY_DEF,
   parameter int KEY_BITS  = KEY_BITS_DEF,
   parameter int HASH_BITS = HASH_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [COUNT_W-1:0]    csr_write_data,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [TYPE_W-1:0]     req_type,
   input  wire logic [KEY_BITS-1:0]   req_key,
   input  wire logic [HASH_BITS-1:0]  req_key_hash,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [SLOT_W-1:0]          rsp_slot,
   output logic [COUNT_W-1:0]         rsp_occupancy
);

   localparam int IDXW = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_HASH   = 3'd2;
   localparam logic [2:0] S_PROBE  = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [IDXW-1:0]     clr_addr_ff, clr_addr_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [COUNT_W-1:0]  max_fill_ff;
   logic                rsp_valid_ff;

   logic [TYPE_W-1:0]   op_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [IDXW-1:0]     iss_pos_ff, iss_pos_in;
   logic [IDXW-1:0]     eval_pos_ff, eval_pos_in;
   logic [CW-1:0]       n_eval_ff, n_eval_in;
   logic                hit_ff, hit_in;
   logic                have_free_ff, have_free_in;
   logic [IDXW-1:0]     free_pos_ff, free_pos_in;
   logic [IDXW-1:0]     hit_pos_ff, hit_pos_in;

   logic [STATUS_W-1:0] rsp_status_ff, status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, slot_in;
   logic [COUNT_W-1:0]  rsp_occupancy_ff;

   logic                req_fire;
   logic                out_free;
   logic                rsp_load;
   logic                ins_ok;
   logic                rem_ok;
   logic                mod_done;
   logic [IDXW-1:0]     mod_pos;
   logic [IDXW-1:0]     mod_next;
   logic [IDXW-1:0]     iss_next;
   logic                cell_occ;
   logic                cell_match;
   logic                free_now;
   logic                probe_stop;

   lphs_mem_ctl_type    mem_ctl;
   logic [IDXW-1:0]     rd_addr;
   logic [IDXW-1:0]     wr_addr;
   lphs_mark_type       wr_mark;
   logic [KEY_BITS-1:0] rd_key;
   lphs_mark_type       rd_mark;

   lphs_mod #(
      .CAPACITY  (CAPACITY),
      .HASH_BITS (HASH_BITS)
   ) u_mod (
      .clock (clock),
      .reset (reset),
      .start (req_fire),
      .hash  (req_key_hash),
      .done  (mod_done),
      .pos   (mod_pos)
   );

   lphs_table #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) u_table (
      .clock   (clock),
      .ctl     (mem_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_key  (key_ff),
      .wr_mark (wr_mark),
      .rd_key  (rd_key),
      .rd_mark (rd_mark)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign mod_next = (mod_pos == IDXW'(CAPACITY - 1)) ? '0 : mod_pos + 1'b1;
   assign iss_next = (iss_pos_ff == IDXW'(CAPACITY - 1)) ? '0 : iss_pos_ff + 1'b1;

   assign cell_occ   = (rd_mark == MARK_OCCUPIED);
   assign cell_match = cell_occ && (rd_key == key_ff);
   assign free_now   = !cell_occ && !have_free_ff;
   assign probe_stop = cell_match || (!cell_occ && (rd_mark != MARK_TOMB)) ||
                       (n_eval_ff == CW'(CAPACITY - 1));

   assign ins_ok = (op_ff == REQ_INSERT) && !hit_ff && have_free_ff &&
                   (count_ff < max_fill_ff);
   assign rem_ok = (op_ff == REQ_REMOVE) && hit_ff;

   always_comb begin
      status_in = STATUS_NOT_FOUND;
      slot_in   = '0;
      case (op_ff)
         REQ_INSERT: begin
            if (hit_ff) begin
               status_in = STATUS_PRESENT;
               slot_in   = SLOT_W'(hit_pos_ff);
            end else if (ins_ok) begin
               status_in = STATUS_INSERTED;
               slot_in   = SLOT_W'(free_pos_ff);
            end else begin
               status_in = STATUS_FULL;
            end
         end
         REQ_LOOKUP: begin
            if (hit_ff) begin
               status_in = STATUS_FOUND;
               slot_in   = SLOT_W'(hit_pos_ff);
            end
         end
         REQ_REMOVE: begin
            if (hit_ff) begin
               status_in = STATUS_REMOVED;
               slot_in   = SLOT_W'(hit_pos_ff);
            end
         end
         default: begin
            status_in = STATUS_NOT_FOUND;
            slot_in   = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      count_in     = count_ff;
      iss_pos_in   = iss_pos_ff;
      eval_pos_in  = eval_pos_ff;
      n_eval_in    = n_eval_ff;
      hit_in       = hit_ff;
      have_free_in = have_free_ff;
      free_pos_in  = free_pos_ff;
      hit_pos_in   = hit_pos_ff;
      mem_ctl      = '0;
      rd_addr      = iss_pos_ff;
      wr_addr      = free_pos_ff;
      wr_mark      = MARK_OCCUPIED;
      rsp_load     = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            mem_ctl.mark_we = 1'b1;
            wr_addr         = clr_addr_ff;
            wr_mark         = MARK_NEVER;
            if (clr_addr_ff == IDXW'(CAPACITY - 1)) begin
               clr_addr_in = '0;
               state_in    = S_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (mod_done) begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = mod_pos;
               eval_pos_in   = mod_pos;
               iss_pos_in    = mod_next;
               n_eval_in     = '0;
               hit_in        = 1'b0;
               have_free_in  = 1'b0;
               state_in      = S_PROBE;
            end
         end
         S_PROBE: begin
            mem_ctl.rd_en = 1'b1;
            rd_addr       = iss_pos_ff;
            eval_pos_in   = iss_pos_ff;
            iss_pos_in    = iss_next;
            n_eval_in     = n_eval_ff + 1'b1;
            if (free_now) begin
               have_free_in = 1'b1;
               free_pos_in  = eval_pos_ff;
            end
            if (probe_stop) begin
               hit_in     = cell_match;
               hit_pos_in = eval_pos_ff;
               state_in   = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
               if (ins_ok) begin
                  mem_ctl.key_we  = 1'b1;
                  mem_ctl.mark_we = 1'b1;
                  wr_addr         = free_pos_ff;
                  wr_mark         = MARK_OCCUPIED;
                  count_in        = count_ff + 1'b1;
               end else if (rem_ok) begin
                  mem_ctl.mark_we = 1'b1;
                  wr_addr         = hit_pos_ff;
                  wr_mark         = MARK_TOMB;
                  if (count_ff != '0) begin
                     count_in = count_ff - 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         count_ff     <= '0;
         max_fill_ff  <= MAX_FILL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         count_ff    <= count_in;
         if (csr_write_enable) begin
            max_fill_ff <= csr_write_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= req_type;
         key_ff <= req_key;
      end
      iss_pos_ff   <= iss_pos_in;
      eval_pos_ff  <= eval_pos_in;
      n_eval_ff    <= n_eval_in;
      hit_ff       <= hit_in;
      have_free_ff <= have_free_in;
      free_pos_ff  <= free_pos_in;
      hit_pos_ff   <= hit_pos_in;
      if (rsp_load) begin
         rsp_status_ff    <= status_in;
         rsp_slot_ff      <= slot_in;
         rsp_occupancy_ff <= count_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_occupancy = rsp_occupancy_ff;

   `LPHS_ASSERT_ALWAYS(a_no_rw_overlap,
      !(mem_ctl.rd_en && (mem_ctl.key_we || mem_ctl.mark_we)),
      "table read and write in the same cycle")
   `LPHS_ASSERT_ALWAYS(a_count_bound, count_ff <= CAPACITY,
      "occupied count exceeds capacity")
   `LPHS_ASSERT_SAME(a_mod_in_hash, mod_done, state_ff == S_HASH,
      "start cell ready outside hash state")
   `LPHS_ASSERT_SAME(a_probe_bound, state_ff == S_PROBE, n_eval_ff < CAPACITY,
      "probe ran past one full pass")
   `LPHS_ASSERT_NEXT(a_insert_count, rsp_load && ins_ok,
      count_ff == $past(count_ff) + 1'b1, "insert did not advance count")

endmodule

`default_nettype wire
